// ===== src/qmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// qmfd_pkg
// Shared types and constants for the quadrature mix / FIR decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package qmfd_pkg;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_BLOCK  = 2'd1,
        KIND_TAP    = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic {
        REG_PHASE_INC = 1'b0,
        REG_DECIM     = 1'b1
    } reg_index_t;

    localparam int TAP_IDX_W = 8;
    localparam int TRIG_BITS = 16;
    localparam int DECIM_W   = 7;
    localparam int COUNT_W   = 6;
    localparam logic [DECIM_W-1:0] MAX_DECIM = 7'd64;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [31:0] A1 = 32'd1686629713;
    localparam logic [31:0] A3 = 32'd693598669;
    localparam logic [31:0] A5 = 32'd85569306;
    localparam logic [31:0] A7 = 32'd5026995;
    localparam logic [31:0] A9 = 32'd172272;

    typedef struct packed {
        logic                 clear;
        logic                 update;
        logic                 tap_we;
        logic [TAP_IDX_W-1:0] tap_idx;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/qmfd_if.sv =====
// ----------------------------------------------------------------------------
// qmfd_in_if / qmfd_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmfd_in_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [5:0]                    tap_index;
    logic signed [COEF_BITS-1:0]   tap_value;

    modport source (output valid, kind, sample, tap_index, tap_value, input ready);
    modport sink (input valid, kind, sample, tap_index, tap_value, output ready);
endinterface

interface qmfd_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] i_out;
    logic signed [SAMPLE_BITS-1:0] q_out;

    modport source (output valid, i_out, q_out, input ready);
    modport sink (input valid, i_out, q_out, output ready);
endinterface

`default_nettype wire

// ===== src/qmfd_nco.sv =====
// ----------------------------------------------------------------------------
// qmfd_nco
// Sequenced odd-polynomial sine and cosine for one quantised phase index.
// ----------------------------------------------------------------------------
`default_nettype none

module qmfd_nco #(
    parameter int LOG_D = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [LOG_D-1:0]                    idx,
    output logic                                     done,
    output logic signed [qmfd_pkg::TRIG_BITS-1:0]    sin_val,
    output logic signed [qmfd_pkg::TRIG_BITS-1:0]    cos_val
);
    import qmfd_pkg::*;

    logic                        busy_reg;
    logic [2:0]                  step_reg;
    logic                        done_reg;
    logic [30:0]                 t_reg   [2];
    logic [30:0]                 t2_reg  [2];
    logic [31:0]                 r_reg   [2];
    logic                        neg_reg [2];
    logic signed [TRIG_BITS-1:0] out_reg [2];

    logic [31:0] ma   [2];
    logic [31:0] mb   [2];
    logic [63:0] prod [2];
    logic [31:0] subc;
    logic [1:0]  quad;
    logic [30:0] t_frac;
    logic [30:0] t_mirror;
    logic [16:0] mag  [2];
    logic [14:0] magc [2];

    assign quad     = idx[LOG_D-1 -: 2];
    assign t_frac   = 31'(idx[LOG_D-3:0]) << (32 - LOG_D);
    assign t_mirror = Q30_ONE - t_frac;

    always_comb
    begin
        unique case (step_reg)
            3'd1:    subc = A7;
            3'd2:    subc = A5;
            3'd3:    subc = A3;
            default: subc = A1;
        endcase
        for (int l = 0; l < 2; l++)
        begin
            unique case (step_reg)
                3'd0:
                begin
                    ma[l] = 32'(t_reg[l]);
                    mb[l] = 32'(t_reg[l]);
                end
                3'd1:
                begin
                    ma[l] = 32'(t2_reg[l]);
                    mb[l] = A9;
                end
                3'd2, 3'd3, 3'd4:
                begin
                    ma[l] = 32'(t2_reg[l]);
                    mb[l] = r_reg[l];
                end
                default:
                begin
                    ma[l] = 32'(t_reg[l]);
                    mb[l] = r_reg[l];
                end
            endcase
            prod[l] = 64'(ma[l]) * 64'(mb[l]);
            mag[l]  = 17'((33'(r_reg[l]) + 33'(1 << 14)) >> 15);
            magc[l] = (mag[l] > 17'd32767) ? 15'd32767 : mag[l][14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 3'd6);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd6)
                    busy_reg <= 1'b0;
                else
                    step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t_reg[0]   <= quad[0] ? t_mirror : t_frac;
            t_reg[1]   <= quad[0] ? t_frac : t_mirror;
            neg_reg[0] <= quad[1];
            neg_reg[1] <= quad[1] ^ quad[0];
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                unique case (step_reg)
                    3'd0:    t2_reg[l] <= prod[l][60:30];
                    3'd1, 3'd2, 3'd3, 3'd4:
                             r_reg[l] <= subc - prod[l][61:30];
                    3'd5:    r_reg[l] <= prod[l][61:30];
                    default: out_reg[l] <= neg_reg[l] ? -TRIG_BITS'(magc[l])
                                                      : TRIG_BITS'(magc[l]);
                endcase
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = out_reg[0];
    assign cos_val = out_reg[1];

endmodule

`default_nettype wire

// ===== src/qmfd_cell.sv =====
// ----------------------------------------------------------------------------
// qmfd_cell
// One transposed FIR cell: holds a tap and the I/Q partial sums.
// ----------------------------------------------------------------------------
`default_nettype none

module qmfd_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    parameter int ACC_W       = 40,
    parameter int INDEX       = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire qmfd_pkg::cell_ctrl_t          ctrl,
    input  wire logic signed [COEF_BITS-1:0]   tap_value,
    input  wire logic signed [SAMPLE_BITS-1:0] mi,
    input  wire logic signed [SAMPLE_BITS-1:0] mq,
    input  wire logic signed [ACC_W-1:0]       p_in_i,
    input  wire logic signed [ACC_W-1:0]       p_in_q,
    output logic signed [ACC_W-1:0]            p_i,
    output logic signed [ACC_W-1:0]            p_q
);
    import qmfd_pkg::*;

    logic signed [COEF_BITS-1:0]             tap_reg;
    logic signed [ACC_W-1:0]                 pi_reg, pi_next;
    logic signed [ACC_W-1:0]                 pq_reg, pq_next;
    logic signed [COEF_BITS+SAMPLE_BITS-1:0] prod_i, prod_q;

    assign prod_i = tap_reg * mi;
    assign prod_q = tap_reg * mq;

    always_comb
    begin
        pi_next = pi_reg;
        pq_next = pq_reg;
        if (ctrl.clear)
        begin
            pi_next = '0;
            pq_next = '0;
        end
        else if (ctrl.update)
        begin
            pi_next = p_in_i + ACC_W'(prod_i);
            pq_next = p_in_q + ACC_W'(prod_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_reg <= '0;
            pq_reg <= '0;
        end
        else
        begin
            pi_reg <= pi_next;
            pq_reg <= pq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tap_we && (ctrl.tap_idx == TAP_IDX_W'(INDEX)))
            tap_reg <= tap_value;
    end

    assign p_i = pi_reg;
    assign p_q = pq_reg;

endmodule

`default_nettype wire

// ===== src/quadrature_mix_fir_decimator_core.sv =====
// ----------------------------------------------------------------------------
// quadrature_mix_fir_decimator_core
// Digital down converter: NCO mix to baseband, FIR low-pass, decimation.
// ----------------------------------------------------------------------------
// One word is taken at a time. A tap write or an unused kind leaves the
// block in idle. A sample passes through these states in order:
//  - the oscillator, whose single multiplier per lane steps through
//    the sine polynomial and then flags completion;
//  - the mixer, the FIR cell row and the result register;
//  - idle again, where the next word is taken.
// A kept result waits in the result register; a further kept sample stalls
// only while it is still full.
// Taps must be loaded before a block of samples and held during it, since
// the FIR cells carry partial sums rather than a delay line.
`default_nettype none

module quadrature_mix_fir_decimator_core #(
    parameter int NUM_TAPS         = 64,
    parameter int SAMPLE_BITS      = 16,
    parameter int COEF_BITS        = 18,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    qmfd_in_if.sink           samples,
    qmfd_out_if.source        results,
    input  wire logic         cfg_write_en,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import qmfd_pkg::*;

    localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(NUM_TAPS);
    localparam int MP_W  = SAMPLE_BITS + TRIG_BITS + 1;
    localparam logic signed [ACC_W:0] SMAX = (ACC_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W:0] SMIN = -SMAX - (ACC_W+1)'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_NCO  = 5'b00010,
        ST_MIX  = 5'b00100,
        ST_FIR  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [31:0]                   phase_inc_reg;
    logic [DECIM_W-1:0]            decim_reg;
    logic [31:0]                   phase_reg, phase_next;
    logic [COUNT_W-1:0]            count_reg, count_next;
    logic                          emit_reg, emit_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] mi_reg, mq_reg;
    logic signed [SAMPLE_BITS-1:0] i_out_reg, q_out_reg;

    logic                          accept, is_sample, load_out;
    logic [31:0]                   phase_base;
    logic [COUNT_W-1:0]            count_base;
    logic [DECIM_W-1:0]            factor;
    logic                          nco_done;
    logic signed [TRIG_BITS-1:0]   sin_val, cos_val;
    logic signed [TRIG_BITS:0]     neg_sin;
    logic signed [MP_W-1:0]        prod_i, prod_q;
    logic signed [MP_W-1:0]        rnd_i, rnd_q;
    logic signed [ACC_W:0]         acc_i, acc_q;
    logic signed [ACC_W:0]         sh_i, sh_q;
    logic signed [SAMPLE_BITS-1:0] sat_i, sat_q;
    cell_ctrl_t                    ctrl;

    logic signed [ACC_W-1:0] p_i [NUM_TAPS+1];
    logic signed [ACC_W-1:0] p_q [NUM_TAPS+1];

    assign accept     = samples.valid && samples.ready;
    assign is_sample  = (kind_t'(samples.kind) == KIND_SAMPLE)
                        || (kind_t'(samples.kind) == KIND_BLOCK);
    assign phase_base = (kind_t'(samples.kind) == KIND_BLOCK) ? 32'd0 : phase_reg;
    assign count_base = (kind_t'(samples.kind) == KIND_BLOCK) ? '0 : count_reg;

    always_comb
    begin
        if (decim_reg == '0)
            factor = DECIM_W'(1);
        else if (decim_reg > MAX_DECIM)
            factor = MAX_DECIM;
        else
            factor = decim_reg;
    end

    qmfd_nco #(
        .LOG_D (LOG_D)
    ) u_nco (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && is_sample),
        .idx     (phase_base[31 -: LOG_D]),
        .done    (nco_done),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    assign neg_sin = -(TRIG_BITS+1)'(sin_val);
    assign prod_i  = MP_W'(x_reg * cos_val);
    assign prod_q  = MP_W'(x_reg * neg_sin);
    assign rnd_i   = (prod_i + MP_W'(1 << 14)) >>> 15;
    assign rnd_q   = (prod_q + MP_W'(1 << 14)) >>> 15;

    assign acc_i = (ACC_W+1)'(p_i[0]) + (ACC_W+1)'(1 << (COEF_BITS - 2));
    assign acc_q = (ACC_W+1)'(p_q[0]) + (ACC_W+1)'(1 << (COEF_BITS - 2));
    assign sh_i  = acc_i >>> (COEF_BITS - 1);
    assign sh_q  = acc_q >>> (COEF_BITS - 1);
    assign sat_i = (sh_i > SMAX) ? SMAX[SAMPLE_BITS-1:0]
                 : (sh_i < SMIN) ? SMIN[SAMPLE_BITS-1:0] : sh_i[SAMPLE_BITS-1:0];
    assign sat_q = (sh_q > SMAX) ? SMAX[SAMPLE_BITS-1:0]
                 : (sh_q < SMIN) ? SMIN[SAMPLE_BITS-1:0] : sh_q[SAMPLE_BITS-1:0];

    assign ctrl.clear   = accept && (kind_t'(samples.kind) == KIND_BLOCK);
    assign ctrl.update  = (state_reg == ST_FIR);
    assign ctrl.tap_we  = accept && (kind_t'(samples.kind) == KIND_TAP);
    assign ctrl.tap_idx = TAP_IDX_W'(samples.tap_index);

    assign p_i[NUM_TAPS] = '0;
    assign p_q[NUM_TAPS] = '0;

    for (genvar k = 0; k < NUM_TAPS; k++)
    begin : g_cell
        qmfd_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .ACC_W       (ACC_W),
            .INDEX       (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .tap_value (samples.tap_value),
            .mi        (mi_reg),
            .mq        (mq_reg),
            .p_in_i    (p_i[k+1]),
            .p_in_q    (p_q[k+1]),
            .p_i       (p_i[k]),
            .p_q       (p_q[k])
        );
    end

    assign load_out = (state_reg == ST_EMIT) && emit_reg
                      && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    phase_next = phase_base + phase_inc_reg;
                    emit_next  = (count_base == '0);
                    if ((DECIM_W'(count_base) + DECIM_W'(1)) >= factor)
                        count_next = '0;
                    else
                        count_next = count_base + COUNT_W'(1);
                    state_next = ST_NCO;
                end
            end
            ST_NCO:
            begin
                if (nco_done)
                    state_next = ST_MIX;
            end
            ST_MIX:  state_next = ST_FIR;
            ST_FIR:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!emit_reg || load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_inc_reg <= '0;
            decim_reg     <= DECIM_W'(1);
            phase_reg     <= '0;
            count_reg     <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_PHASE_INC: phase_inc_reg <= cfg_data;
                    REG_DECIM:     decim_reg     <= cfg_data[DECIM_W-1:0];
                    default:       phase_inc_reg <= phase_inc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_sample)
            x_reg <= samples.sample;
        if (state_reg == ST_MIX)
        begin
            mi_reg <= rnd_i[SAMPLE_BITS-1:0];
            mq_reg <= rnd_q[SAMPLE_BITS-1:0];
        end
        if (load_out)
        begin
            i_out_reg <= sat_i;
            q_out_reg <= sat_q;
        end
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.i_out = i_out_reg;
    assign results.q_out = q_out_reg;

`ifndef SYNTHESIS
    a_nco_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        nco_done |-> state_reg == ST_NCO)
        else $error("oscillator finished outside its wait state");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT) && $past(emit_reg))
        else $error("result loaded without a kept sample");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (DECIM_W'(count_reg) < MAX_DECIM))
        else $error("decimation count out of range");
`endif

endmodule

`default_nettype wire
